/* hw/rtl/hjrs_pkg.sv */
package hjrs_pkg;

    // table geometry, slot count must be a power of two
    localparam int TABLE_SLOTS = 1024;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TABLE_SLOTS - 1);

    // field widths
    localparam int KEY_W     = 31;
    localparam int DATE_W    = 27;
    localparam int PREFIX_W  = 40;
    localparam int PRICE_W   = 24;
    localparam int DISC_W    = 7;
    localparam int SUM_W     = 63;
    localparam int REV_W     = PRICE_W + DISC_W;
    localparam int CFG_IDX_W = 1;

    // constants
    localparam logic [31:0]         HASH_MUL      = 32'd2654435761;
    localparam logic [PREFIX_W-1:0] PROMO_PREFIX  = 40'h50524F4D4F;
    localparam logic [SUM_W-1:0]    SUM_MAX       = '1;
    localparam logic [DATE_W-1:0]   DATE_FROM_RST = 27'd19950901;
    localparam logic [DATE_W-1:0]   DATE_UNTIL_RST = 27'd19951001;
    localparam logic [DISC_W-1:0]   DISC_FULL     = 7'd100;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DATE_FROM  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DATE_UNTIL = 1'b1;

    typedef enum logic [1:0] {
        OP_INSERT       = 2'd0,
        OP_PROBE        = 2'd1,
        OP_CLEAR_TOTALS = 2'd2,
        OP_CLEAR_TABLE  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_INSERTED      = 3'd0,
        ST_UPDATED       = 3'd1,
        ST_MATCHED       = 3'd2,
        ST_DATE_FILTERED = 3'd3,
        ST_NO_MATCH      = 3'd4,
        ST_BAD_KEY       = 3'd5,
        ST_TABLE_FULL    = 3'd6,
        ST_CLEARED       = 3'd7
    } status_t;

    typedef struct packed {
        opcode_t               opcode;
        logic signed [31:0]    join_key;
        logic [PREFIX_W-1:0]   type_prefix;
        logic [DATE_W-1:0]     ship_date;
        logic [PRICE_W-1:0]    price_cents;
        logic [DISC_W-1:0]     discount_hundredths;
    } row_t;

    typedef struct packed {
        status_t               status;
        logic                  row_is_promo;
        logic [SUM_W-1:0]      promo_total;
        logic [SUM_W-1:0]      revenue_total;
    } result_t;

    // one table slot, key zero marks an empty slot
    typedef struct packed {
        logic [KEY_W-1:0]      key;
        logic                  promo;
    } slot_t;

    typedef struct packed {
        logic                  en;
        logic [SLOT_W-1:0]     addr;
        slot_t                 data;
    } slot_wr_t;

    typedef struct packed {
        logic                  en;
        logic [SLOT_W-1:0]     addr;
    } slot_rd_t;

endpackage

/* hw/rtl/hjrs_channels.sv */
// lineitem and part row channel
interface hjrs_row_if;
    logic             valid;
    logic             ready;
    hjrs_pkg::row_t   item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// result channel
interface hjrs_result_if;
    logic              valid;
    logic              ready;
    hjrs_pkg::result_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

/* hw/rtl/hjrs_slot_ram.sv */
module hjrs_slot_ram (
    input  logic                clk,
    input  hjrs_pkg::slot_wr_t  wr,
    input  hjrs_pkg::slot_rd_t  rd,
    output hjrs_pkg::slot_t     rd_data
);

    hjrs_pkg::slot_t mem [hjrs_pkg::TABLE_SLOTS];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule

/* hw/rtl/hash_join_revenue_sum_top.sv */
// channel   dir  payload                                                  transaction
// rows      in   opcode, join_key, type_prefix, ship_date, price, discount valid & ready
// results   out  status, row_is_promo, promo_total, revenue_total          valid & ready
// cfg       in   cfg_index, cfg_data                                      cfg_we
//
// insert and probe pass through S_HASH, S_LOOKUP, S_PROBE and S_DONE, the linear probe
// reading one slot per cycle from the table ram; clear totals, bad key and date
// filtered rows go from S_HASH to S_DONE; clear table first sweeps every slot in S_CLEAR.
// after reset a clearing pass writes every slot with rows.ready low.
// one row is in flight at a time; a finished result waits in the output register and
// the next row is accepted while it waits.
module hash_join_revenue_sum_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [hjrs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hjrs_pkg::DATE_W-1:0]        cfg_data,
    hjrs_row_if.sink                           rows,
    hjrs_result_if.source                      results
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_HASH,
        S_LOOKUP,
        S_PROBE,
        S_CLEAR,
        S_DONE
    } state_t;

    state_t                               state_reg;
    logic [hjrs_pkg::DATE_W-1:0]          date_from_reg;
    logic [hjrs_pkg::DATE_W-1:0]          date_until_reg;

    hjrs_pkg::opcode_t                    op_reg;
    logic [hjrs_pkg::KEY_W-1:0]           key_reg;
    logic                                 key_ok_reg;
    logic                                 date_ok_reg;
    logic                                 promo_new_reg;
    logic [hjrs_pkg::PRICE_W-1:0]         price_reg;
    logic [hjrs_pkg::DISC_W-1:0]          factor_reg;

    logic [hjrs_pkg::SLOT_W-1:0]          hash_reg;
    logic [hjrs_pkg::REV_W-1:0]           rev_reg;
    logic [hjrs_pkg::SLOT_W-1:0]          slot_reg;
    logic [hjrs_pkg::SLOT_W-1:0]          count_reg;
    logic [hjrs_pkg::SLOT_W-1:0]          clr_cnt_reg;

    logic [hjrs_pkg::SUM_W-1:0]           revenue_sum_reg;
    logic [hjrs_pkg::SUM_W-1:0]           promo_sum_reg;
    hjrs_pkg::status_t                    res_status_reg;
    logic                                 res_promo_reg;

    logic                                 out_valid_reg;
    hjrs_pkg::result_t                    out_item_reg;

    logic                                 row_fire;
    logic [hjrs_pkg::DISC_W-1:0]          disc_sat;
    logic [31:0]                          hash_word;
    logic [hjrs_pkg::REV_W-1:0]           rev_full;
    hjrs_pkg::slot_t                      rd_slot;
    hjrs_pkg::slot_wr_t                   slot_wr;
    hjrs_pkg::slot_rd_t                   slot_rd;
    logic                                 slot_empty;
    logic                                 slot_hit;
    logic                                 probe_last;
    logic                                 probe_step;
    logic [hjrs_pkg::SLOT_W-1:0]          slot_inc;
    logic [hjrs_pkg::SUM_W:0]             rev_add;
    logic [hjrs_pkg::SUM_W:0]             promo_add;
    logic [hjrs_pkg::SUM_W-1:0]           rev_sat;
    logic [hjrs_pkg::SUM_W-1:0]           promo_sat;

    // handshake
    assign rows.ready    = (state_reg == S_IDLE);
    assign row_fire      = rows.valid && rows.ready;
    assign results.valid = out_valid_reg;
    assign results.item  = out_item_reg;

    // discount capped at one hundred hundredths
    assign disc_sat = (rows.item.discount_hundredths > hjrs_pkg::DISC_FULL)
                      ? hjrs_pkg::DISC_FULL : rows.item.discount_hundredths;

    // registered multiplies: hash slot and row revenue
    assign hash_word = 32'({1'b0, key_reg} * hjrs_pkg::HASH_MUL);
    assign rev_full  = hjrs_pkg::REV_W'(price_reg) * hjrs_pkg::REV_W'(factor_reg);

    // probe decision on the slot just read
    assign slot_empty = (rd_slot.key == '0);
    assign slot_hit   = (rd_slot.key == key_reg);
    assign probe_last = (count_reg == hjrs_pkg::SLOT_LAST);
    assign probe_step = !(slot_empty || slot_hit || probe_last);
    assign slot_inc   = slot_reg + 1'b1;

    // saturating accumulation
    assign rev_add   = {1'b0, revenue_sum_reg} + (hjrs_pkg::SUM_W + 1)'(rev_reg);
    assign promo_add = {1'b0, promo_sum_reg} + (hjrs_pkg::SUM_W + 1)'(rev_reg);
    assign rev_sat   = rev_add[hjrs_pkg::SUM_W] ? hjrs_pkg::SUM_MAX
                                                : rev_add[hjrs_pkg::SUM_W-1:0];
    assign promo_sat = promo_add[hjrs_pkg::SUM_W] ? hjrs_pkg::SUM_MAX
                                                  : promo_add[hjrs_pkg::SUM_W-1:0];

    // table read port
    always_comb
    begin
        slot_rd.en   = 1'b0;
        slot_rd.addr = hash_reg;
        if (state_reg == S_LOOKUP)
        begin
            slot_rd.en = 1'b1;
        end
        else if ((state_reg == S_PROBE) && probe_step)
        begin
            slot_rd.en   = 1'b1;
            slot_rd.addr = slot_inc;
        end
    end

    // table write port: clearing pass or insert
    always_comb
    begin
        slot_wr.en   = 1'b0;
        slot_wr.addr = slot_reg;
        slot_wr.data = '0;
        if ((state_reg == S_INIT) || (state_reg == S_CLEAR))
        begin
            slot_wr.en   = 1'b1;
            slot_wr.addr = clr_cnt_reg;
        end
        else if ((state_reg == S_PROBE) && (op_reg == hjrs_pkg::OP_INSERT)
                 && (slot_empty || slot_hit))
        begin
            slot_wr.en         = 1'b1;
            slot_wr.data.key   = key_reg;
            slot_wr.data.promo = promo_new_reg;
        end
    end

    hjrs_slot_ram u_slot_ram (
        .clk     (clk),
        .wr      (slot_wr),
        .rd      (slot_rd),
        .rd_data (rd_slot)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            date_from_reg  <= hjrs_pkg::DATE_FROM_RST;
            date_until_reg <= hjrs_pkg::DATE_UNTIL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hjrs_pkg::CFG_DATE_FROM:  date_from_reg  <= cfg_data;
                hjrs_pkg::CFG_DATE_UNTIL: date_until_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer, totals and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_INIT;
            op_reg          <= hjrs_pkg::OP_INSERT;
            key_reg         <= '0;
            key_ok_reg      <= 1'b0;
            date_ok_reg     <= 1'b0;
            promo_new_reg   <= 1'b0;
            price_reg       <= '0;
            factor_reg      <= '0;
            hash_reg        <= '0;
            rev_reg         <= '0;
            slot_reg        <= '0;
            count_reg       <= '0;
            clr_cnt_reg     <= '0;
            revenue_sum_reg <= '0;
            promo_sum_reg   <= '0;
            res_status_reg  <= hjrs_pkg::ST_CLEARED;
            res_promo_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_item_reg    <= '0;
        end
        else
        begin
            // S_DONE reloads the output register itself when ready is high
            if (results.ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                // clearing pass after reset
                S_INIT:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == hjrs_pkg::SLOT_LAST)
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                // latch the row and its field checks
                S_IDLE:
                begin
                    if (row_fire)
                    begin
                        op_reg        <= rows.item.opcode;
                        key_reg       <= rows.item.join_key[hjrs_pkg::KEY_W-1:0];
                        key_ok_reg    <= (rows.item.join_key != '0) && !rows.item.join_key[31];
                        date_ok_reg   <= (rows.item.ship_date >= date_from_reg)
                                         && (rows.item.ship_date < date_until_reg);
                        promo_new_reg <= (rows.item.type_prefix == hjrs_pkg::PROMO_PREFIX);
                        price_reg     <= rows.item.price_cents;
                        factor_reg    <= hjrs_pkg::DISC_FULL - disc_sat;
                        state_reg     <= S_HASH;
                    end
                end

                // hash and revenue products, early outcomes
                S_HASH:
                begin
                    hash_reg      <= hash_word[hjrs_pkg::SLOT_W-1:0];
                    rev_reg       <= rev_full;
                    res_promo_reg <= 1'b0;
                    case (op_reg)
                        hjrs_pkg::OP_INSERT:
                        begin
                            if (!key_ok_reg)
                            begin
                                res_status_reg <= hjrs_pkg::ST_BAD_KEY;
                                state_reg      <= S_DONE;
                            end
                            else
                            begin
                                state_reg <= S_LOOKUP;
                            end
                        end
                        hjrs_pkg::OP_PROBE:
                        begin
                            if (!date_ok_reg)
                            begin
                                res_status_reg <= hjrs_pkg::ST_DATE_FILTERED;
                                state_reg      <= S_DONE;
                            end
                            else if (!key_ok_reg)
                            begin
                                res_status_reg <= hjrs_pkg::ST_BAD_KEY;
                                state_reg      <= S_DONE;
                            end
                            else
                            begin
                                state_reg <= S_LOOKUP;
                            end
                        end
                        hjrs_pkg::OP_CLEAR_TOTALS:
                        begin
                            revenue_sum_reg <= '0;
                            promo_sum_reg   <= '0;
                            res_status_reg  <= hjrs_pkg::ST_CLEARED;
                            state_reg       <= S_DONE;
                        end
                        default:
                        begin
                            clr_cnt_reg    <= '0;
                            res_status_reg <= hjrs_pkg::ST_CLEARED;
                            state_reg      <= S_CLEAR;
                        end
                    endcase
                end

                // first slot read is in flight
                S_LOOKUP:
                begin
                    slot_reg  <= hash_reg;
                    count_reg <= '0;
                    state_reg <= S_PROBE;
                end

                // one slot per cycle along the probe sequence
                S_PROBE:
                begin
                    if (probe_step)
                    begin
                        slot_reg  <= slot_inc;
                        count_reg <= count_reg + 1'b1;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                        if (op_reg == hjrs_pkg::OP_INSERT)
                        begin
                            if (slot_empty)
                            begin
                                res_status_reg <= hjrs_pkg::ST_INSERTED;
                                res_promo_reg  <= promo_new_reg;
                            end
                            else if (slot_hit)
                            begin
                                res_status_reg <= hjrs_pkg::ST_UPDATED;
                                res_promo_reg  <= promo_new_reg;
                            end
                            else
                            begin
                                res_status_reg <= hjrs_pkg::ST_TABLE_FULL;
                            end
                        end
                        else if (slot_hit)
                        begin
                            res_status_reg  <= hjrs_pkg::ST_MATCHED;
                            res_promo_reg   <= rd_slot.promo;
                            revenue_sum_reg <= rev_sat;
                            if (rd_slot.promo)
                            begin
                                promo_sum_reg <= promo_sat;
                            end
                        end
                        else
                        begin
                            res_status_reg <= hjrs_pkg::ST_NO_MATCH;
                        end
                    end
                end

                // clear table sweep
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == hjrs_pkg::SLOT_LAST)
                    begin
                        state_reg <= S_DONE;
                    end
                end

                // hand the result to the output register
                S_DONE:
                begin
                    if (!out_valid_reg || results.ready)
                    begin
                        out_valid_reg              <= 1'b1;
                        out_item_reg.status        <= res_status_reg;
                        out_item_reg.row_is_promo  <= res_promo_reg;
                        out_item_reg.promo_total   <= promo_sum_reg;
                        out_item_reg.revenue_total <= revenue_sum_reg;
                        state_reg                  <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* test/revenue_join_tb_pkg.sv */
package revenue_join_tb_pkg;

    import hjrs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // mirror of the part table and revenue totals, checks each result transaction
    class revenue_join_scoreboard;

        bit [KEY_W-1:0]  slot_key [TABLE_SLOTS];
        bit              slot_promo [TABLE_SLOTS];
        bit [SUM_W-1:0]  promo_sum;
        bit [SUM_W-1:0]  revenue_sum;
        bit [DATE_W-1:0] date_from;
        bit [DATE_W-1:0] date_until;
        result_t         join_results_due [$];
        int              errors;
        int              reported;

        function new();
            empty_table();
            promo_sum   = '0;
            revenue_sum = '0;
            date_from   = DATE_FROM_RST;
            date_until  = DATE_UNTIL_RST;
            errors      = 0;
            reported    = 0;
        endfunction

        function void empty_table();
            foreach (slot_key[i])
            begin
                slot_key[i]   = '0;
                slot_promo[i] = 1'b0;
            end
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DATE_W-1:0] value);
            if (idx == CFG_DATE_FROM)
                date_from = value;
            else if (idx == CFG_DATE_UNTIL)
                date_until = value;
        endfunction

        // home slot: low bits of the 32 bit product of key and multiplier
        function logic [SLOT_W-1:0] home_slot(logic [31:0] key);
            logic [31:0] h;
            h = key * HASH_MUL;
            return SLOT_W'(h % TABLE_SLOTS);
        endfunction

        function logic [SUM_W-1:0] add_saturated(logic [SUM_W-1:0] a, logic [63:0] b);
            logic [63:0] s;
            s = {1'b0, a} + b;
            return (s > {1'b0, SUM_MAX}) ? SUM_MAX : s[SUM_W-1:0];
        endfunction

        // apply one accepted row to the mirror and queue the result it must produce
        function void join_row(row_t r);
            result_t          res;
            logic [31:0]      key;
            logic [SLOT_W-1:0] s;
            int               n;
            bit               key_ok;
            bit               done;
            logic [DISC_W-1:0] disc;
            logic [63:0]      rev;

            key    = r.join_key;
            key_ok = (key != 32'd0) && !key[31];
            res.status       = ST_CLEARED;
            res.row_is_promo = 1'b0;
            s    = home_slot(key);
            n    = 0;
            done = 1'b0;

            case (r.opcode)
                OP_INSERT:
                begin
                    if (!key_ok)
                        res.status = ST_BAD_KEY;
                    else
                    begin
                        res.status = ST_TABLE_FULL;
                        while (!done && n < TABLE_SLOTS)
                        begin
                            if (slot_key[s] == '0 || slot_key[s] == key[KEY_W-1:0])
                            begin
                                res.status = (slot_key[s] == '0) ? ST_INSERTED : ST_UPDATED;
                                res.row_is_promo = (r.type_prefix == PROMO_PREFIX);
                                slot_key[s]   = key[KEY_W-1:0];
                                slot_promo[s] = res.row_is_promo;
                                done = 1'b1;
                            end
                            else
                            begin
                                s = s + 1'b1;
                                n++;
                            end
                        end
                    end
                end
                OP_PROBE:
                begin
                    if (r.ship_date < date_from || r.ship_date >= date_until)
                        res.status = ST_DATE_FILTERED;
                    else if (!key_ok)
                        res.status = ST_BAD_KEY;
                    else
                    begin
                        res.status = ST_NO_MATCH;
                        while (!done && n < TABLE_SLOTS && slot_key[s] != '0)
                        begin
                            if (slot_key[s] == key[KEY_W-1:0])
                            begin
                                // discount above a full hundred counts as a full hundred
                                disc = (r.discount_hundredths > DISC_FULL) ?
                                       DISC_FULL : r.discount_hundredths;
                                rev  = 64'(r.price_cents) * (64'(DISC_FULL) - 64'(disc));
                                res.status       = ST_MATCHED;
                                res.row_is_promo = slot_promo[s];
                                revenue_sum = add_saturated(revenue_sum, rev);
                                if (slot_promo[s])
                                    promo_sum = add_saturated(promo_sum, rev);
                                done = 1'b1;
                            end
                            else
                            begin
                                s = s + 1'b1;
                                n++;
                            end
                        end
                    end
                end
                OP_CLEAR_TOTALS:
                begin
                    promo_sum   = '0;
                    revenue_sum = '0;
                end
                default:
                    empty_table();
            endcase

            res.promo_total   = promo_sum;
            res.revenue_total = revenue_sum;
            join_results_due.push_back(res);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (join_results_due.size() == 0)
            begin
                errors++;
                if (reported < 10)
                begin
                    reported++;
                    $display("unexpected result transaction: status %0d promo %0b", got.status,
                             got.row_is_promo);
                end
                return;
            end
            want = join_results_due.pop_front();
            if (got.status !== want.status || got.row_is_promo !== want.row_is_promo ||
                got.promo_total !== want.promo_total ||
                got.revenue_total !== want.revenue_total)
            begin
                errors++;
                if (reported < 10)
                begin
                    reported++;
                    $display("mismatch: expected status %0d promo %0b promo_total %0d revenue %0d",
                             want.status, want.row_is_promo, want.promo_total,
                             want.revenue_total);
                    $display("          actual   status %0d promo %0b promo_total %0d revenue %0d",
                             got.status, got.row_is_promo, got.promo_total, got.revenue_total);
                end
            end
        endfunction

        function int pending();
            return join_results_due.size();
        endfunction

    endclass

endpackage

/* test/tb_hash_join_revenue_sum_top.sv */
module tb_hash_join_revenue_sum_top;

    import hjrs_pkg::*;
    import revenue_join_tb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [DATE_W-1:0] DATE_MAX = '1;
    localparam int RANDOM_PHASES   = 6;
    localparam int ROWS_PER_PHASE  = 100;
    localparam int FILL_KEYS       = 64;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATE_W-1:0]    cfg_data;

    int send_gap_pct;
    int recv_stall_pct;

    hjrs_row_if    rows_ch ();
    hjrs_result_if res_ch ();

    revenue_join_scoreboard sb = new();

    hash_join_revenue_sum_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rows      (rows_ch),
        .results   (res_ch)
    );

    always #10 clk = ~clk;

    // result side back-pressure
    always @(negedge clk)
        res_ch.ready = ($urandom_range(99) >= recv_stall_pct);

    // result transactions
    always @(posedge clk)
        if (rst_n && res_ch.valid && res_ch.ready)
            sb.check_result(res_ch.item);

    // hard stop
    initial
    begin
        #(100_000_000);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic row_t make_row(opcode_t op, logic signed [31:0] key,
                                      logic [PREFIX_W-1:0] prefix, logic [DATE_W-1:0] date,
                                      logic [PRICE_W-1:0] price, logic [DISC_W-1:0] disc);
        row_t r;
        r.opcode              = op;
        r.join_key            = key;
        r.type_prefix         = prefix;
        r.ship_date           = date;
        r.price_cents         = price;
        r.discount_hundredths = disc;
        return r;
    endfunction

    // mostly keys from a small pool plus one long collision chain, some bad keys
    function automatic row_t rand_row();
        row_t              r;
        int unsigned       pick;
        logic [DATE_W-1:0] lo;
        logic [DATE_W-1:0] hi;

        lo   = sb.date_from;
        hi   = sb.date_until;
        pick = $urandom_range(99);
        if (pick < 35)
            r.opcode = OP_INSERT;
        else if (pick < 92)
            r.opcode = OP_PROBE;
        else if (pick < 97)
            r.opcode = OP_CLEAR_TOTALS;
        else
            r.opcode = OP_CLEAR_TABLE;

        pick = $urandom_range(99);
        if (pick < 3)
            r.join_key = '0;
        else if (pick < 5)
            r.join_key = 32'sh8000_0000;
        else if (pick < 8)
            r.join_key = $urandom | 32'h8000_0000;
        else if (pick < 13)
            r.join_key = $urandom_range(32'h7fff_ffff, 1);
        else if (pick < 15)
            r.join_key = 32'h7fff_ffff;
        else if (pick < 60)
            r.join_key = $urandom_range(48, 1);
        else
            r.join_key = 7 + 1024 * $urandom_range(15);

        pick = $urandom_range(99);
        if (pick < 45)
            r.type_prefix = PROMO_PREFIX;
        else if (pick < 55)
            r.type_prefix = PROMO_PREFIX ^ (40'd1 << $urandom_range(PREFIX_W - 1));
        else
            r.type_prefix = {$urandom, 8'($urandom)};

        pick = $urandom_range(99);
        if (pick < 70 && hi > lo)
            r.ship_date = lo + DATE_W'($urandom % (hi - lo));
        else if (pick < 85)
        begin
            case ($urandom_range(3))
                0:       r.ship_date = lo - 1'b1;
                1:       r.ship_date = lo;
                2:       r.ship_date = hi - 1'b1;
                default: r.ship_date = hi;
            endcase
        end
        else
            r.ship_date = DATE_W'($urandom);

        pick = $urandom_range(99);
        if (pick < 10)
            r.price_cents = '1;
        else if (pick < 15)
            r.price_cents = '0;
        else
            r.price_cents = PRICE_W'($urandom);

        pick = $urandom_range(99);
        if (pick < 10)
            r.discount_hundredths = DISC_W'($urandom_range(127, 101));
        else if (pick < 20)
            r.discount_hundredths = $urandom_range(1) ? DISC_FULL : 7'd0;
        else
            r.discount_hundredths = DISC_W'($urandom_range(100));
        return r;
    endfunction

    // one row transaction, with random gaps ahead of it
    task automatic send_row(input row_t r);
        while ($urandom_range(99) < send_gap_pct)
        begin
            rows_ch.valid = 1'b0;
            @(negedge clk);
        end
        rows_ch.valid = 1'b1;
        rows_ch.item  = r;
        @(posedge clk);
        while (!rows_ch.ready)
            @(posedge clk);
        sb.join_row(r);
        @(negedge clk);
        rows_ch.valid = 1'b0;
    endtask

    task automatic wait_results_done();
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATE_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.set_reg(idx, value);
    endtask

    // window changes only once the block has gone quiet
    task automatic set_window(input logic [DATE_W-1:0] from, input logic [DATE_W-1:0] to_date);
        wait_results_done();
        repeat (8) @(negedge clk);
        write_reg(CFG_DATE_FROM, from);
        write_reg(CFG_DATE_UNTIL, to_date);
    endtask

    initial
    begin
        int                n;
        int                phase;
        logic [DATE_W-1:0] d_in;
        logic [DATE_W-1:0] lo;

        rows_ch.valid  = 1'b0;
        rows_ch.item   = '0;
        res_ch.ready   = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_DATE_FROM;
        cfg_data       = '0;
        send_gap_pct   = 25;
        recv_stall_pct = 52;
        rst_n          = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // directed rows under the reset window
        d_in = 27'd19950915;
        send_row(make_row(OP_PROBE, 5, '0, d_in, 24'd100, 7'd0));
        send_row(make_row(OP_INSERT, 1, PROMO_PREFIX, d_in, '0, '0));
        send_row(make_row(OP_INSERT, 1, 40'h50524F4D4E, d_in, '0, '0));
        send_row(make_row(OP_INSERT, 1, PROMO_PREFIX, d_in, '0, '0));
        send_row(make_row(OP_INSERT, 32'sh7fff_ffff, '1, d_in, '0, '0));
        send_row(make_row(OP_INSERT, 0, PROMO_PREFIX, d_in, '0, '0));
        send_row(make_row(OP_INSERT, -32'sd1, PROMO_PREFIX, d_in, '0, '0));
        send_row(make_row(OP_INSERT, 32'sh8000_0000, PROMO_PREFIX, d_in, '0, '0));
        send_row(make_row(OP_INSERT, 1025, PROMO_PREFIX, d_in, '0, '0));
        send_row(make_row(OP_PROBE, 1025, '0, DATE_FROM_RST, '1, 7'd0));
        send_row(make_row(OP_PROBE, 32'sh7fff_ffff, '0, DATE_UNTIL_RST - 1'b1, '1, DISC_FULL));
        send_row(make_row(OP_PROBE, 1, '0, d_in, 24'd5000, 7'd127));
        send_row(make_row(OP_PROBE, 1, '0, DATE_UNTIL_RST, 24'd5000, 7'd3));
        send_row(make_row(OP_PROBE, 1, '0, DATE_FROM_RST - 1'b1, 24'd5000, 7'd3));
        send_row(make_row(OP_PROBE, 0, '0, d_in, 24'd5000, 7'd3));
        send_row(make_row(OP_PROBE, -32'sd5, '0, 27'd20000101, 24'd5000, 7'd3));
        send_row(make_row(OP_PROBE, 2049, '0, d_in, 24'd5000, 7'd3));
        send_row(make_row(OP_CLEAR_TOTALS, 1, '1, '1, '1, '1));
        send_row(make_row(OP_PROBE, 1, '0, d_in, 24'd1234, 7'd7));
        send_row(make_row(OP_CLEAR_TABLE, 1, '0, '0, '0, '0));
        send_row(make_row(OP_PROBE, 1, '0, d_in, 24'd1234, 7'd7));
        send_row(make_row(OP_INSERT, 1, '0, d_in, '0, '0));

        // a run of consecutive keys, each in its own slot
        set_window('0, DATE_MAX);
        send_row(make_row(OP_CLEAR_TABLE, 1, '0, '0, '0, '0));
        for (n = 1; n <= FILL_KEYS; n++)
            send_row(make_row(OP_INSERT, n, $urandom_range(1) ? PROMO_PREFIX : '0, '0, '0, '0));
        send_row(make_row(OP_INSERT, 5000, PROMO_PREFIX, '0, '0, '0));
        send_row(make_row(OP_INSERT, 77, PROMO_PREFIX, '0, '0, '0));
        send_row(make_row(OP_PROBE, 77, '0, 27'd5, 24'd999, 7'd10));
        send_row(make_row(OP_PROBE, 3000, '0, 27'd5, 24'd999, 7'd10));
        send_row(make_row(OP_PROBE, 2, '0, DATE_MAX, 24'd999, 7'd10));
        send_row(make_row(OP_INSERT, -32'sd7, PROMO_PREFIX, '0, '0, '0));
        send_row(make_row(OP_CLEAR_TABLE, 1, '0, '0, '0, '0));

        // random rows across several windows and idle patterns
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 2)
            begin
                send_gap_pct   = 52;
                recv_stall_pct = 25;
            end
            else if (phase == 4)
            begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            case (phase)
                0: set_window('0, DATE_MAX);
                1: set_window(DATE_FROM_RST, DATE_UNTIL_RST);
                2:
                begin
                    lo = DATE_W'($urandom);
                    set_window(lo, lo);
                end
                3: set_window(DATE_MAX, '0);
                4:
                begin
                    lo = DATE_W'($urandom_range(99_990_000));
                    set_window(lo, lo + DATE_W'($urandom_range(5000, 1)));
                end
                default: set_window(27'd19000101, 27'd20251231);
            endcase
            repeat (ROWS_PER_PHASE)
            begin
                if ($urandom_range(99) == 0)
                    wait_results_done();
                send_row(rand_row());
            end
        end

        wait_results_done();
        repeat (16) @(negedge clk);
        if (sb.errors + sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
